// ===== rtl/kdru_pkg.sv =====
// shared widths and defaults for the knapsack row update unit
// no dependencies
package kdru_pkg;

   localparam int CAP_W                = 10;
   localparam int WEIGHT_W             = 10;
   localparam int ITEM_VALUE_W         = 8;
   localparam int VALUE_W              = 24;
   localparam int REQ_DATA_W           = 24;
   localparam int RSP_DATA_W           = 24;
   localparam int MAX_CAPACITY_ENTRIES = 1024;

   localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(20);
   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

endpackage

// ===== rtl/kdru_ram.sv =====
// generic ram: one write port, two read ports with registered read data
// no dependencies
module kdru_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== rtl/knapsack_dp_row_update_unit.sv =====
// knapsack row update unit: top level, sweep sequencer and clearing pass
// depends on kdru_pkg and kdru_ram
// each req beat sweeps n row entries, n = capacity - weight + 1
//   (n = 1 when weight exceeds capacity); one row entry per cycle through ram
// a new req beat is taken only in idle, once the previous item's rsp is registered
// reset and last item: clearing pass zeroes all MAX_CAPACITY_ENTRIES entries, no req taken
module knapsack_dp_row_update_unit #(
   parameter int MAX_CAPACITY_ENTRIES = kdru_pkg::MAX_CAPACITY_ENTRIES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [kdru_pkg::CAP_W-1:0]        csr_wr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // item_weight [9:0], item_value [17:10], zero pad
   input  logic [kdru_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // best_value [23:0]
   output logic [kdru_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);
   import kdru_pkg::*;

   localparam int AW = $clog2(MAX_CAPACITY_ENTRIES);
   localparam int CW = (CAP_W > AW) ? CAP_W : AW;
   localparam logic [CW-1:0] MAX_ADDR = CW'(MAX_CAPACITY_ENTRIES - 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CAPACITY_ENTRIES - 1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SWEEP  = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_RESULT = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [CAP_W-1:0]        cap_ff, cap_in;
   logic [AW-1:0]           addr_ff, addr_in;
   logic [AW-1:0]           eff_cap_ff, eff_cap_in;
   logic [AW-1:0]           weight_ff, weight_in;
   logic [ITEM_VALUE_W-1:0] value_ff, value_in;
   logic                    last_ff, last_in;
   logic                    upd_ff, upd_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [AW-1:0]           rd_addr_ff, rd_addr_in;
   logic [VALUE_W-1:0]      result_ff, result_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [CW-1:0]           cap_ext, eff_ext, weight_ext;
   logic                    req_fire;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [VALUE_W-1:0]      wr_data;
   logic [AW-1:0]           rd_addr_b;
   logic [VALUE_W-1:0]      rd_data_a, rd_data_b;
   logic [VALUE_W:0]        sum;
   logic [VALUE_W-1:0]      cand, new_val;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign cap_ext    = CW'(cap_ff);
   assign eff_ext    = (cap_ext > MAX_ADDR) ? MAX_ADDR : cap_ext;
   assign weight_ext = CW'(req_tdata[WEIGHT_W-1:0]);

   assign rd_addr_b = addr_ff - weight_ff;
   assign sum       = {1'b0, rd_data_b} + (VALUE_W + 1)'(value_ff);
   assign cand      = sum[VALUE_W] ? VALUE_MAX : sum[VALUE_W-1:0];
   assign new_val   = (cand > rd_data_a) ? cand : rd_data_a;

   assign wr_en   = (state_ff == ST_CLEAR) || (rd_vld_ff && upd_ff);
   assign wr_addr = (state_ff == ST_CLEAR) ? addr_ff : rd_addr_ff;
   assign wr_data = (state_ff == ST_CLEAR) ? '0 : new_val;

   kdru_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_CAPACITY_ENTRIES)
   ) u_row (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (addr_ff),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   always_comb begin
      state_in     = state_ff;
      cap_in       = csr_wr_en ? csr_wr_data : cap_ff;
      addr_in      = addr_ff;
      eff_cap_in   = eff_cap_ff;
      weight_in    = weight_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      upd_in       = upd_ff;
      rd_vld_in    = 1'b0;
      rd_addr_in   = rd_addr_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (rd_vld_ff && (rd_addr_ff == eff_cap_ff)) begin
         result_in = upd_ff ? new_val : rd_data_a;
      end

      case (state_ff)
         ST_CLEAR: begin
            addr_in = addr_ff + AW'(1);
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               eff_cap_in = eff_ext[AW-1:0];
               addr_in    = eff_ext[AW-1:0];
               upd_in     = (weight_ext <= eff_ext);
               weight_in  = weight_ext[AW-1:0];
               value_in   = req_tdata[WEIGHT_W +: ITEM_VALUE_W];
               last_in    = req_tlast;
               state_in   = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            rd_vld_in  = 1'b1;
            rd_addr_in = addr_ff;
            if (!upd_ff || (addr_ff == weight_ff)) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff - AW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               rsp_last_in  = last_ff;
               addr_in      = '0;
               state_in     = last_ff ? ST_CLEAR : ST_IDLE;
            end
         end
         default: begin
            addr_in  = '0;
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cap_ff       <= CAP_RESET;
         addr_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         addr_ff      <= addr_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      eff_cap_ff  <= eff_cap_in;
      weight_ff   <= weight_in;
      value_ff    <= value_in;
      last_ff     <= last_in;
      upd_ff      <= upd_in;
      rd_addr_ff  <= rd_addr_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !wr_en)
      else $error("row written while idle");

   a_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT) |-> !rd_vld_ff)
      else $error("row update still in flight at result");

   a_accept_sweep: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SWEEP))
      else $error("accepted beat did not start a sweep");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("rsp raised outside result state");

endmodule

// ===== tb/knapsack_dp_row_update_unit_test.sv =====
// self-checking testbench for knapsack_dp_row_update_unit: directed and random item streams
// with random source gaps and sink stalls, checked beat by beat against a row-sweep predictor
// depends on kdru_pkg and the knapsack_dp_row_update_unit rtl
`timescale 1ns / 1ps

typedef struct {
   logic [kdru_pkg::VALUE_W-1:0] best_value;
   logic                         last_result;
} knapsack_answer_type;

class knapsack_scoreboard;
   bit [kdru_pkg::VALUE_W-1:0] best_row [kdru_pkg::MAX_CAPACITY_ENTRIES];
   bit [kdru_pkg::CAP_W-1:0]   capacity;
   knapsack_answer_type        pending_answers [$];
   int                         mismatch_count;

   function new();
      foreach (best_row[i]) best_row[i] = '0;
      capacity = kdru_pkg::CAP_RESET;
      mismatch_count = 0;
   endfunction

   function void set_capacity(input logic [kdru_pkg::CAP_W-1:0] value);
      capacity = value;
   endfunction

   // sweep the row downward for one accepted item and queue the expected answer
   function void note_item(input logic [kdru_pkg::WEIGHT_W-1:0] weight,
                           input logic [kdru_pkg::ITEM_VALUE_W-1:0] value,
                           input logic last);
      int               cap;
      int               c;
      bit [kdru_pkg::VALUE_W:0] cand;
      knapsack_answer_type answer;
      cap = int'(capacity);
      if (cap > kdru_pkg::MAX_CAPACITY_ENTRIES - 1) cap = kdru_pkg::MAX_CAPACITY_ENTRIES - 1;
      if (int'(weight) <= cap) begin
         for (c = cap; c >= int'(weight); c--) begin
            cand = {1'b0, best_row[c - int'(weight)]} + value;
            if (cand > kdru_pkg::VALUE_MAX) cand = kdru_pkg::VALUE_MAX;
            if (cand[kdru_pkg::VALUE_W-1:0] > best_row[c])
               best_row[c] = cand[kdru_pkg::VALUE_W-1:0];
         end
      end
      answer.best_value  = best_row[cap];
      answer.last_result = last;
      if (last) foreach (best_row[i]) best_row[i] = '0;
      pending_answers.push_back(answer);
   endfunction

   task report(input string what, input longint got, input longint want);
      if (mismatch_count < 40)
         $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task check_result(input logic [kdru_pkg::RSP_DATA_W-1:0] data, input logic last);
      knapsack_answer_type answer;
      if (pending_answers.size() == 0) begin
         report("rsp beat with nothing pending, best_value", data, 0);
      end else begin
         answer = pending_answers.pop_front();
         if (data[kdru_pkg::VALUE_W-1:0] !== answer.best_value)
            report("best_value", data[kdru_pkg::VALUE_W-1:0], answer.best_value);
         if (last !== answer.last_result)
            report("last_result", last, answer.last_result);
      end
   endtask
endclass

module knapsack_dp_row_update_unit_test;
   localparam int CLOCK_PERIOD      = 12;
   localparam int WATCHDOG_LIMIT    = 20000;
   localparam int SETTLE_CYCLES     = kdru_pkg::MAX_CAPACITY_ENTRIES + 16;
   localparam int ZERO_WEIGHT_ITEMS = 8;
   localparam int RANDOM_ITEMS      = 540;
   localparam int PAD_W             = kdru_pkg::REQ_DATA_W - kdru_pkg::WEIGHT_W
                                      - kdru_pkg::ITEM_VALUE_W;

   logic                               clock       = 1'b0;
   logic                               reset       = 1'b1;
   logic                               csr_wr_en   = 1'b0;
   logic [kdru_pkg::CAP_W-1:0]         csr_wr_data = '0;
   logic                               req_tvalid  = 1'b0;
   logic                               req_tready;
   logic [kdru_pkg::REQ_DATA_W-1:0]    req_tdata   = '0;
   logic                               req_tlast   = 1'b0;
   logic                               rsp_tvalid;
   logic                               rsp_tready  = 1'b0;
   logic [kdru_pkg::RSP_DATA_W-1:0]    rsp_tdata;
   logic                               rsp_tlast;

   knapsack_scoreboard sb = new;
   bit gaps_on   = 1'b1;
   bit stalls_on = 1'b1;
   int random_count = 0;
   int idle_cycles  = 0;

   knapsack_dp_row_update_unit uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(16, 60);
   endfunction

   // sink side stalls
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (!stalls_on || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
         end else begin
            n = pick_gap() + 1;
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_item(input logic [kdru_pkg::WEIGHT_W-1:0] weight,
                            input logic [kdru_pkg::ITEM_VALUE_W-1:0] value,
                            input logic last);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{PAD_W{1'b0}}, value, weight};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_item(weight, value, last);
   endtask

   // drain, let any clearing pass finish, then write the register
   task automatic write_capacity(input int value);
      req_tvalid <= 1'b0;
      while (sb.pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[kdru_pkg::CAP_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_capacity(value[kdru_pkg::CAP_W-1:0]);
   endtask

   task automatic random_item(input int cap, input int last_pct);
      logic [kdru_pkg::WEIGHT_W-1:0]     weight;
      logic [kdru_pkg::ITEM_VALUE_W-1:0] value;
      int r;
      int pick;
      r = $urandom_range(0, 99);
      if (r < 8) pick = 0;
      else if (r < 16) pick = cap;
      else if (r < 26) pick = $urandom_range(0, 1023);
      else if (r < 32 && cap < 1023) pick = cap + 1;
      else pick = $urandom_range(0, cap);
      weight = pick[kdru_pkg::WEIGHT_W-1:0];
      r = $urandom_range(0, 99);
      if (r < 10) pick = 255;
      else if (r < 15) pick = 0;
      else pick = $urandom_range(0, 255);
      value = pick[kdru_pkg::ITEM_VALUE_W-1:0];
      send_item(weight, value, $urandom_range(0, 99) < last_pct);
      random_count++;
   endtask

   initial begin
      int cap;
      int n;
      int r;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset capacity: zero weight, weight at and above capacity, widest fields
      send_item(10'd0, 8'd255, 1'b0);
      send_item(10'd20, 8'd1, 1'b0);
      send_item(10'd21, 8'd200, 1'b0);
      send_item(10'd1023, 8'd255, 1'b0);
      send_item(10'd5, 8'd0, 1'b0);
      send_item(10'd7, 8'd100, 1'b0);
      send_item(10'd13, 8'd120, 1'b0);
      send_item(10'd3, 8'd50, 1'b0);
      send_item(10'd10, 8'd255, 1'b1);

      write_capacity(0);
      send_item(10'd0, 8'd77, 1'b0);
      send_item(10'd1, 8'd9, 1'b0);
      send_item(10'd0, 8'd255, 1'b1);

      write_capacity(1023);
      send_item(10'd1023, 8'd255, 1'b0);
      send_item(10'd512, 8'd128, 1'b0);
      send_item(10'd0, 8'd1, 1'b0);
      send_item(10'd1, 8'd3, 1'b0);
      send_item(10'd511, 8'd44, 1'b1);

      // capacity moved down and back up inside one set
      write_capacity(30);
      send_item(10'd4, 8'd40, 1'b0);
      send_item(10'd30, 8'd99, 1'b0);
      write_capacity(10);
      send_item(10'd2, 8'd5, 1'b0);
      write_capacity(30);
      send_item(10'd0, 8'd1, 1'b1);

      // back-to-back zero weight items with no gaps or stalls
      write_capacity(1);
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      repeat (ZERO_WEIGHT_ITEMS) send_item(10'd0, 8'd255, 1'b0);
      send_item(10'd1, 8'd255, 1'b0);
      send_item(10'd0, 8'd200, 1'b0);
      write_capacity(3);
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      send_item(10'd2, 8'd255, 1'b0);
      send_item(10'd1, 8'd1, 1'b1);

      while (random_count < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            cap = 1023;
            n = $urandom_range(4, 8);
         end else if (r < 18) begin
            cap = 0;
            n = $urandom_range(10, 30);
         end else if (r < 30) begin
            cap = $urandom_range(0, 1023);
            n = $urandom_range(4, 8);
         end else begin
            cap = $urandom_range(1, 60);
            n = $urandom_range(15, 40);
         end
         write_capacity(cap);
         gaps_on   = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         repeat (n) random_item(cap, (cap > 60) ? 20 : 12);
      end

      req_tvalid <= 1'b0;
      while (sb.pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.pending_answers.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
